>>> rtl/hsv_to_rgb_converter_macros.svh
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_macros.svh
// assertion macros shared by the converter checker
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// clocked assertion, off while rst is high
`define HSV2RGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define HSV2RGB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// widths, constants and sector codes of the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned CHANNEL_BITS = 16;
  localparam int unsigned HUE_W        = 15;
  localparam int unsigned SECTOR_W     = 3;
  localparam int unsigned NUM_SECTORS  = 6;
  localparam int unsigned REM_W        = 12;   // remainder within a sector, < 3840
  localparam int unsigned FRAC_W       = 16;   // Q0.16 position inside a sector

  localparam logic [CHANNEL_BITS-1:0] FULL_SCALE = '1;

  // a full turn is 360 * 64 units, one sector 60 * 64
  localparam int unsigned HUE_TURN_INT   = 360 * 64;
  localparam int unsigned HUE_SECTOR_INT = 60 * 64;
  localparam logic [HUE_W-1:0] HUE_TURN   = HUE_W'(HUE_TURN_INT);
  localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(HUE_SECTOR_INT);

  // frac = (rem << 16) / 3840 = (rem * 256) / 15, done as rem * ceil(2^24 / 15) >> 16
  localparam int unsigned FF_SHIFT    = 24;
  localparam int unsigned FF_RECIP_W  = 21;
  localparam int unsigned FF_PROD_W   = REM_W + FF_RECIP_W;
  localparam int unsigned FF_LSB      = FF_SHIFT - 8;
  localparam logic [FF_RECIP_W-1:0] FF_RECIP =
    FF_RECIP_W'(((1 << FF_SHIFT) + 15 - 1) / 15);

  // sectors, named after the hue where each one starts
  typedef enum logic [SECTOR_W-1:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

endpackage

>>> rtl/hsv2rgb_in_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb_in_if
// valid/ready channel carrying one hsv pixel
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
  import hsv2rgb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [HUE_W-1:0]        hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

>>> rtl/hsv2rgb_out_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb_out_if
// valid/ready channel carrying one rgb pixel
// ----------------------------------------------------------------------------
interface hsv2rgb_out_if;
  import hsv2rgb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hsv2rgb_hue_split.sv
// ----------------------------------------------------------------------------
// hsv2rgb_hue_split
// folds out-of-range hue to zero, splits it into sector and remainder
// ----------------------------------------------------------------------------
module hsv2rgb_hue_split (
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue,
  output hsv2rgb_pkg::sector_t          sector,
  output logic [hsv2rgb_pkg::REM_W-1:0] rem
);
  import hsv2rgb_pkg::*;

  logic [HUE_W-1:0]    hue_fold;
  logic [HUE_W-1:0]    base;
  logic [SECTOR_W-1:0] idx;

  always_comb begin
    hue_fold = (hue >= HUE_TURN) ? '0 : hue;
    idx      = '0;
    base     = '0;
    // sector boundaries are constants, so these are plain compares
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (hue_fold >= HUE_W'(k * HUE_SECTOR_INT)) begin
        idx  = SECTOR_W'(k);
        base = HUE_W'(k * HUE_SECTOR_INT);
      end
    end
    sector = sector_t'(idx);
    rem    = REM_W'(hue_fold - base);
  end

endmodule

>>> rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// fixed-point hsv to rgb pixel conversion, five-stage pipeline
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+-----------
//  hsv     | in  | hue 15b, saturation, brightness  | valid/ready
//  rgb     | out | red, green, blue (16b each)      | valid/ready
//
//  one pixel per clock sustained while rgb is ready; an input transfer
//  passes hue split, sector fraction, s products, v products and /FULL
//  rst clears only the stage valid bits; the datapath registers hold junk
//  each stage loads when it is empty or its successor moves, so a stall on
//  rgb fills the bubbles first and back-pressures hsv only when all is full
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic          clk,
  input  logic          rst,
  hsv2rgb_in_if.sink    hsv,
  hsv2rgb_out_if.source rgb
);
  import hsv2rgb_pkg::*;

  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned LAST       = NUM_STAGES - 1;
  localparam int unsigned CB         = CHANNEL_BITS;

  // divide by 2^CB - 1 exactly for x <= (2^CB - 1)^2
  function automatic logic [CB-1:0] div_full(input logic [2*CB-1:0] x);
    logic [2*CB:0] sum;
    sum = {1'b0, x} + (2*CB+1)'(x >> CB) + (2*CB+1)'(1);
    return sum[2*CB-1:CB];
  endfunction

  // per-stage valid and load enable
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] ce;

  always_comb begin
    ce[LAST] = !vld[LAST] || rgb.ready;
    for (int i = int'(LAST) - 1; i >= 0; i--) begin
      ce[i] = !vld[i] || ce[i+1];
    end
  end

  assign hsv.ready = ce[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ce[0]) begin
        vld[0] <= hsv.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ce[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: sector and remainder within the sector
  sector_t          split_sector;
  logic [REM_W-1:0] split_rem;

  hsv2rgb_hue_split u_hue_split (
    .hue    (hsv.hue),
    .sector (split_sector),
    .rem    (split_rem)
  );

  sector_t          s1_sector;
  logic [REM_W-1:0] s1_rem;
  logic [CB-1:0]    s1_sat;
  logic [CB-1:0]    s1_bri;
  logic             s1_grey;

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      s1_sector <= split_sector;
      s1_rem    <= split_rem;
      s1_sat    <= hsv.saturation;
      s1_bri    <= hsv.brightness;
      s1_grey   <= (hsv.saturation == '0);
    end
  end

  // stage 2: Q0.16 fraction, reciprocal multiply instead of a divide by 3840
  logic [FF_PROD_W-1:0] ff_prod;
  assign ff_prod = FF_PROD_W'(s1_rem) * FF_PROD_W'(FF_RECIP);

  sector_t           s2_sector;
  logic [FRAC_W-1:0] s2_ff;
  logic [CB-1:0]     s2_sat;
  logic [CB-1:0]     s2_bri;
  logic              s2_grey;

  always_ff @(posedge clk) begin
    if (ce[1]) begin
      s2_sector <= s1_sector;
      s2_ff     <= ff_prod[FF_LSB+FRAC_W-1:FF_LSB];
      s2_sat    <= s1_sat;
      s2_bri    <= s1_bri;
      s2_grey   <= s1_grey;
    end
  end

  // stage 3: s * f and s * (1 - f), then the three scale factors
  logic [FRAC_W:0]          ff_cmp;
  logic [CB+FRAC_W-1:0]     sf_prod;
  logic [CB+FRAC_W:0]       sfc_prod;
  logic [CB-1:0]            kp;
  logic [CB-1:0]            kq;
  logic [CB-1:0]            kt;

  always_comb begin
    ff_cmp   = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, s2_ff};
    sf_prod  = (CB+FRAC_W)'(s2_sat) * (CB+FRAC_W)'(s2_ff);
    sfc_prod = (CB+FRAC_W+1)'(s2_sat) * (CB+FRAC_W+1)'(ff_cmp);
    // both shifted products stay at or below s, so no underflow
    kp = FULL_SCALE - s2_sat;
    kq = FULL_SCALE - sf_prod[FRAC_W+CB-1:FRAC_W];
    kt = FULL_SCALE - sfc_prod[FRAC_W+CB-1:FRAC_W];
  end

  sector_t       s3_sector;
  logic [CB-1:0] s3_kp;
  logic [CB-1:0] s3_kq;
  logic [CB-1:0] s3_kt;
  logic [CB-1:0] s3_bri;
  logic          s3_grey;

  always_ff @(posedge clk) begin
    if (ce[2]) begin
      s3_sector <= s2_sector;
      s3_kp     <= kp;
      s3_kq     <= kq;
      s3_kt     <= kt;
      s3_bri    <= s2_bri;
      s3_grey   <= s2_grey;
    end
  end

  // stage 4: v times each scale factor
  sector_t         s4_sector;
  logic [2*CB-1:0] s4_xp;
  logic [2*CB-1:0] s4_xq;
  logic [2*CB-1:0] s4_xt;
  logic [CB-1:0]   s4_bri;
  logic            s4_grey;

  always_ff @(posedge clk) begin
    if (ce[3]) begin
      s4_sector <= s3_sector;
      s4_xp     <= (2*CB)'(s3_bri) * (2*CB)'(s3_kp);
      s4_xq     <= (2*CB)'(s3_bri) * (2*CB)'(s3_kq);
      s4_xt     <= (2*CB)'(s3_bri) * (2*CB)'(s3_kt);
      s4_bri    <= s3_bri;
      s4_grey   <= s3_grey;
    end
  end

  // stage 5: divide by full scale and route by sector into the output register
  logic [CB-1:0] p_val;
  logic [CB-1:0] q_val;
  logic [CB-1:0] t_val;
  logic [CB-1:0] red_next;
  logic [CB-1:0] green_next;
  logic [CB-1:0] blue_next;

  always_comb begin
    p_val = div_full(s4_xp);
    q_val = div_full(s4_xq);
    t_val = div_full(s4_xt);
    if (s4_grey) begin
      red_next   = s4_bri;
      green_next = s4_bri;
      blue_next  = s4_bri;
    end else begin
      unique case (s4_sector)
        SEC_RED: begin
          red_next = s4_bri; green_next = t_val;  blue_next = p_val;
        end
        SEC_YELLOW: begin
          red_next = q_val;  green_next = s4_bri; blue_next = p_val;
        end
        SEC_GREEN: begin
          red_next = p_val;  green_next = s4_bri; blue_next = t_val;
        end
        SEC_CYAN: begin
          red_next = p_val;  green_next = q_val;  blue_next = s4_bri;
        end
        SEC_BLUE: begin
          red_next = t_val;  green_next = p_val;  blue_next = s4_bri;
        end
        default: begin
          red_next = s4_bri; green_next = p_val;  blue_next = q_val;
        end
      endcase
    end
  end

  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;

  always_ff @(posedge clk) begin
    if (ce[LAST]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign rgb.valid = vld[LAST];
  assign rgb.red   = red;
  assign rgb.green = green;
  assign rgb.blue  = blue;

endmodule

>>> rtl/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsv2rgb_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] red,
  input logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] green,
  input logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] blue
);
  import hsv2rgb_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // reset empties the pipeline
  `HSV2RGB_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid, "output valid after reset")

  // a taken output means every stage can move, so the input side is open
  `HSV2RGB_ASSERT_ALWAYS(a_ready_chain, out_ready |-> in_ready, "input stalled while output drains")

  // a held result keeps its pixel
  `HSV2RGB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue), "stalled output changed")

  // with the output blocked and full, a transfer in needs a free stage
  `HSV2RGB_ASSERT(a_no_overrun, in_xfer && out_valid && !out_ready |-> !$past(out_valid && !out_ready, 5) || !$past(in_xfer, 1) || !$past(in_xfer, 2) || !$past(in_xfer, 3) || !$past(in_xfer, 4), "more transfers than stages during a stall")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (hsv.valid),
  .in_ready  (hsv.ready),
  .out_valid (rgb.valid),
  .out_ready (rgb.ready),
  .red       (rgb.red),
  .green     (rgb.green),
  .blue      (rgb.blue)
);
